FILE: src/ual_pkg.sv
// ============================================================================
// ual_pkg - shared definitions for the unordered array list
// Sizes, command and status codes, controller states and the ring control
// bundle that passes from the controller to the chain of entry cells.
// ============================================================================
package ual_pkg;

    // list capacity and the widths that follow from it
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = 11;   // count and position fields are fixed at 11 bits
    localparam int VAL_W  = 32;
    localparam int POS_W  = 11;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd3;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS1,
        ST_PASS2,
        ST_FINISH
    } ctrl_state_t;

    // ring control: shift enable and the word that enters the tail cell
    typedef struct packed {
        logic             shift;
        logic [VAL_W-1:0] feed;
    } ring_ctrl_t;

endpackage

FILE: src/ual_cell.sv
// ============================================================================
// ual_cell - one entry of the list ring
// Holds one 32-bit entry and takes its neighbor's entry whenever the ring
// shifts.
// ============================================================================
module ual_cell (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [ual_pkg::VAL_W-1:0]   din,
    output logic [ual_pkg::VAL_W-1:0]   dout
);

    logic [ual_pkg::VAL_W-1:0] entry_reg;
    logic [ual_pkg::VAL_W-1:0] entry_next;

    // take the neighbor's entry on a shift, hold otherwise
    always_comb
    begin
        entry_next = shift ? din : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign dout = entry_reg;

endmodule

FILE: src/ual_chain.sv
// ============================================================================
// ual_chain - ring of entry cells
// A row of DEPTH cells. On each shift every cell takes the entry of the next
// cell up and the tail cell takes the feed word; cell 0 is the head.
// ============================================================================
module ual_chain (
    input  logic                        clk,
    input  ual_pkg::ring_ctrl_t         ring,
    output logic [ual_pkg::VAL_W-1:0]   head
);

    logic [ual_pkg::VAL_W-1:0] cell_q [ual_pkg::DEPTH];

    // build the row, each cell fed by its upper neighbor
    genvar i;
    generate
        for (i = 0; i < ual_pkg::DEPTH; i++)
        begin : g_cell
            if (i == ual_pkg::DEPTH - 1)
            begin : g_tail
                ual_cell u_cell (
                    .clk   (clk),
                    .shift (ring.shift),
                    .din   (ring.feed),
                    .dout  (cell_q[i])
                );
            end
            else
            begin : g_body
                ual_cell u_cell (
                    .clk   (clk),
                    .shift (ring.shift),
                    .din   (cell_q[i+1]),
                    .dout  (cell_q[i])
                );
            end
        end
    endgenerate

    assign head = cell_q[0];

endmodule

FILE: src/ual_ctrl.sv
// ============================================================================
// ual_ctrl - command sequencer for the list ring
// Takes a command, rotates the ring once (twice for a remove that hits, not
// at all for a rejected command), compares and rewrites entries as they pass
// the head, then posts the item in the output register.
// ============================================================================
module ual_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ual_pkg::CMD_W-1:0]    in_command,
    input  logic [ual_pkg::VAL_W-1:0]    in_value,
    input  logic [ual_pkg::POS_W-1:0]    in_position,
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ual_pkg::STAT_W-1:0]   out_status,
    output logic [ual_pkg::CNT_W-1:0]    out_found_position,
    output logic [ual_pkg::CNT_W-1:0]    out_entry_count,
    // ring
    input  logic [ual_pkg::VAL_W-1:0]    head,
    output ual_pkg::ring_ctrl_t          ring
);

    ual_pkg::ctrl_state_t state_reg, state_next;

    logic [ual_pkg::IDX_W-1:0]  step_reg, step_next;
    logic [ual_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;

    logic [ual_pkg::CMD_W-1:0]  cmd_reg;
    logic [ual_pkg::VAL_W-1:0]  val_reg;
    logic [ual_pkg::POS_W-1:0]  pos_reg;
    logic [ual_pkg::STAT_W-1:0] status_reg;
    logic [ual_pkg::CNT_W-1:0]  found_reg;
    logic [ual_pkg::VAL_W-1:0]  held_reg;
    logic [ual_pkg::STAT_W-1:0] out_status_reg;
    logic [ual_pkg::CNT_W-1:0]  out_found_reg;
    logic [ual_pkg::CNT_W-1:0]  out_count_reg;

    logic                       accept;
    logic                       out_free;
    logic                       finish_go;
    logic                       last_step;
    logic [ual_pkg::CNT_W-1:0]  step_ext;
    logic [ual_pkg::CNT_W-1:0]  count_m1;
    logic [ual_pkg::CNT_W-1:0]  pos_m1;
    logic [ual_pkg::CNT_W-1:0]  found_m1;
    logic                       hit;
    logic [ual_pkg::CNT_W-1:0]  found_now;
    logic                       is_scan;
    logic                       in_full;
    logic                       in_bad_pos;
    logic [ual_pkg::STAT_W-1:0] in_status;
    logic [ual_pkg::STAT_W-1:0] final_status;

    // common terms
    always_comb
    begin
        accept    = s_tvalid && s_tready;
        out_free  = !out_valid_reg || m_tready;
        finish_go = (state_reg == ual_pkg::ST_FINISH) && out_free;
        last_step = (step_reg == ual_pkg::IDX_W'(ual_pkg::DEPTH - 1));
        step_ext  = ual_pkg::CNT_W'(step_reg);
        count_m1  = count_reg - 1'b1;
        pos_m1    = ual_pkg::CNT_W'(pos_reg) - 1'b1;
        found_m1  = found_reg - 1'b1;
        is_scan   = (cmd_reg == ual_pkg::CMD_SEARCH) || (cmd_reg == ual_pkg::CMD_REMOVE);
        // only search and remove look for a match
        hit       = is_scan && (step_ext < count_reg) && (head == val_reg) &&
                    (found_reg == '0);
        found_now = hit ? (step_ext + 1'b1) : found_reg;
    end

    // classify the incoming command: rejected ones skip the ring
    always_comb
    begin
        in_full    = (count_reg >= ual_pkg::CNT_W'(ual_pkg::DEPTH));
        in_bad_pos = (in_position == '0) ||
                     ({1'b0, in_position} > ({1'b0, count_reg} + 1'b1));
        unique case (in_command)
            ual_pkg::CMD_SEARCH: in_status = ual_pkg::STAT_OK;
            ual_pkg::CMD_REMOVE: in_status = ual_pkg::STAT_OK;
            ual_pkg::CMD_INSERT:
            begin
                if (in_full)
                    in_status = ual_pkg::STAT_FULL;
                else if (in_bad_pos)
                    in_status = ual_pkg::STAT_BAD_POS;
                else
                    in_status = ual_pkg::STAT_OK;
            end
            default:             in_status = ual_pkg::STAT_BAD_POS;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ual_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (in_status == ual_pkg::STAT_OK) ? ual_pkg::ST_PASS1
                                                                 : ual_pkg::ST_FINISH;
            end
            ual_pkg::ST_PASS1:
            begin
                if (last_step)
                    state_next = ((cmd_reg == ual_pkg::CMD_REMOVE) && (found_now != '0))
                                 ? ual_pkg::ST_PASS2 : ual_pkg::ST_FINISH;
            end
            ual_pkg::ST_PASS2:
            begin
                if (last_step)
                    state_next = ual_pkg::ST_FINISH;
            end
            ual_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = ual_pkg::ST_IDLE;
            end
            default: state_next = ual_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and ring control
    always_comb
    begin
        s_tready   = 1'b0;
        ring.shift = 1'b0;
        ring.feed  = head;
        unique case (state_reg)
            ual_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ual_pkg::ST_PASS1:
            begin
                ring.shift = 1'b1;
                // insert: new value at its slot, displaced entry at the end
                if (cmd_reg == ual_pkg::CMD_INSERT)
                begin
                    if (step_ext == pos_m1)
                        ring.feed = val_reg;
                    else if (step_ext == count_reg)
                        ring.feed = held_reg;
                end
            end
            ual_pkg::ST_PASS2:
            begin
                ring.shift = 1'b1;
                // remove: last entry fills the slot of the match
                if (step_ext == found_m1)
                    ring.feed = held_reg;
            end
            ual_pkg::ST_FINISH:
            begin
                s_tready = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // step, count and output valid
    always_comb
    begin
        step_next = step_reg;
        if (ring.shift)
            step_next = last_step ? '0 : (step_reg + 1'b1);

        count_next = count_reg;
        if (finish_go && (status_reg == ual_pkg::STAT_OK))
        begin
            if (cmd_reg == ual_pkg::CMD_INSERT)
                count_next = count_reg + 1'b1;
            else if ((cmd_reg == ual_pkg::CMD_REMOVE) && (found_reg != '0))
                count_next = count_reg - 1'b1;
        end

        final_status = (is_scan && (found_reg == '0)) ? ual_pkg::STAT_NOT_FOUND : status_reg;

        if (finish_go)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ual_pkg::ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command, scan and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= in_command;
            val_reg    <= in_value;
            pos_reg    <= in_position;
            status_reg <= in_status;
            found_reg  <= '0;
        end
        else if (state_reg == ual_pkg::ST_PASS1)
        begin
            found_reg <= found_now;
            // capture the displaced entry or the last entry
            if (((cmd_reg == ual_pkg::CMD_INSERT) && (step_ext == pos_m1)) ||
                ((cmd_reg == ual_pkg::CMD_REMOVE) && (step_ext == count_m1)))
                held_reg <= head;
        end

        if (finish_go)
        begin
            out_status_reg <= final_status;
            out_found_reg  <= found_reg;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid           = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_found_position = out_found_reg;
    assign out_entry_count    = out_count_reg;

endmodule

FILE: src/unordered_array_list_top.sv
// ============================================================================
// unordered_array_list_top - unordered list of 32-bit values
// Search, insert and remove on a list held in a ring of entry cells.
// ============================================================================
//
// Commands enter on the s_ channel (s_tuser = command, s_tdata = value and
// position); each command gives one item on the m_ channel with status,
// found position and the entry count after the command.
// The entries sit in a ring of DEPTH cells. A command rotates the whole ring
// once, one entry past the head comparator per cycle, so the ring turn sets
// the rate. A remove with a match turns the ring a second time to move the
// last entry into the freed slot; a rejected command leaves the ring
// untouched.
// One command is in work at a time; s_tready is high only while idle, which
// starts in the same cycle that the result posts. A finished item waits in
// the output register, and the block takes the next command while it waits;
// if that command finishes before the receiver takes the waiting item, it
// holds until m_tready frees the register.
// Reset clears the count and the control state; entry contents are not
// cleared and are never read before they are written.
//
module unordered_array_list_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] value, [42:32] position, zero above
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] status, [12:2] found_position, [23:13] entry_count
);

    logic [ual_pkg::VAL_W-1:0]  head;
    ual_pkg::ring_ctrl_t        ring;
    logic [ual_pkg::STAT_W-1:0] status;
    logic [ual_pkg::CNT_W-1:0]  found_position;
    logic [ual_pkg::CNT_W-1:0]  entry_count;

    // sequencer
    ual_ctrl u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .in_command         (s_tuser),
        .in_value           (s_tdata[31:0]),
        .in_position        (s_tdata[42:32]),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .out_status         (status),
        .out_found_position (found_position),
        .out_entry_count    (entry_count),
        .head               (head),
        .ring               (ring)
    );

    // entry ring
    ual_chain u_chain (
        .clk  (clk),
        .ring (ring),
        .head (head)
    );

    // pack the result item
    assign m_tdata = {entry_count, found_position, status};

endmodule

FILE: src/ual_checker.sv
// ============================================================================
// ual_checker - port checks for the unordered array list
// Watches the top level's channels and flags results that break the list's
// rules or the stream handshake.
// ============================================================================
module ual_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    // one command at a time: no accept right after an accept
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in work");

    // failed commands report no position
    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ual_pkg::STAT_OK) |-> m_tdata[12:2] == 11'd0)
        else $error("position reported on a failed command");

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:13] <= 11'(ual_pkg::DEPTH))
        else $error("entry count above capacity");

    // a found position is at most one past the reported entry count
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> {1'b0, m_tdata[12:2]} <= ({1'b0, m_tdata[23:13]} + 12'd1))
        else $error("found position beyond the list");

endmodule

bind unordered_array_list_top ual_checker u_ual_checker (.*);
